### rtl/core/open_addressing_hash_set_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hash set core.
// Each macro expects signals named clock and reset in the scope of use.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_SET_CORE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_SET_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OHS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OHS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/ohs_pkg.sv
// ----------------------------------------------------------------------------
// ohs_pkg
// Types and constants shared by the hash set core and its channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ohs_pkg;

   // Table geometry.
   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 64;
   localparam int SLOT_W   = 8;
   localparam int OP_W     = 3;
   localparam int STAT_W   = 2;

   // Command queue geometry.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // Operation codes; codes 6 and 7 have no meaning.
   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP     = 3'd0,
      OP_INSERT     = 3'd1,
      OP_DELETE_KEY = 3'd2,
      OP_DELETE_AT  = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_READ       = 3'd5
   } op_type;

   // Result status codes.
   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_FREE  = 2'd1,
      ST_BAD_SLOT = 2'd2
   } status_type;

   // One classified command as it waits in the queue.
   typedef struct packed {
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [IDX_W-1:0]  start;
      logic              probe;
   } cmd_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

### rtl/core/ohs_if.sv
// ----------------------------------------------------------------------------
// ohs channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ohs_req_if;
   import ohs_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [KEY_W-1:0]  key;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, op, key, slot, input ready);
   modport sink   (input valid, op, key, slot, output ready);
endinterface

interface ohs_rsp_if;
   import ohs_pkg::*;

   logic              valid;
   logic              ready;
   logic              hit;
   logic [STAT_W-1:0] status;
   logic [SLOT_W-1:0] where;
   logic [KEY_W-1:0]  key_out;
   logic [CNT_W-1:0]  live_count;

   modport source (output valid, hit, status, where, key_out, live_count, input ready);
   modport sink   (input valid, hit, status, where, key_out, live_count, output ready);
endinterface

### rtl/core/ohs_front.sv
// ----------------------------------------------------------------------------
// ohs_front
// Accepts request beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohs_front (
   input  logic                    clock,
   input  logic                    reset,
   ohs_req_if.sink                 req_bus,
   output ohs_pkg::queue_head_type head,
   input  logic                    pop
);
   import ohs_pkg::*;

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   logic               push;
   cmd_type            cmd_new;

   // Classify the incoming beat: probe operations start at the home slot,
   // slot operations at the given slot.
   always_comb begin
      cmd_new.op  = op_type'(req_bus.op);
      cmd_new.key = req_bus.key;
      case (op_type'(req_bus.op)) inside
         OP_LOOKUP, OP_INSERT, OP_DELETE_KEY: begin
            cmd_new.start = req_bus.key[IDX_W-1:0];
            cmd_new.probe = 1'b1;
         end
         default: begin
            cmd_new.start = IDX_W'(req_bus.slot);
            cmd_new.probe = 1'b0;
         end
      endcase
   end

   assign req_bus.ready = (fill_ff != QFILL_W'(QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;

   // Pointer and fill bookkeeping; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      fill_in = fill_ff + QFILL_W'(push) - QFILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

endmodule

### rtl/core/ohs_back.sv
// ----------------------------------------------------------------------------
// ohs_back
// Runs one command at a time: walks the table by linear probing, updates the
// keys, marks and count, and registers the response beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ohs_pkg::queue_head_type head,
   output logic                    pop,
   ohs_rsp_if.source               rsp_bus
);
   import ohs_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  steps_ff, steps_in;
   logic [IDX_W-1:0]  free_ff, free_in;
   logic              have_free_ff, have_free_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CAPACITY-1:0] valid_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              hit_ff, hit_in;
   status_type        status_ff, status_in;
   logic [SLOT_W-1:0] where_ff, where_in;
   logic [KEY_W-1:0]  key_out_ff, key_out_in;
   logic [CNT_W-1:0]  live_ff, live_in;

   // Table memories: key per slot, and full (1) versus deleted (0) per slot.
   logic [KEY_W-1:0]  key_mem_ff [CAPACITY];
   logic              full_mem_ff [CAPACITY];
   logic [KEY_W-1:0]  key_rd_ff;
   logic              full_rd_ff;

   logic              key_we, full_we, full_wd, valid_set, valid_clear;
   logic [IDX_W-1:0]  wa;
   logic              out_free;
   logic              mark_full, mark_empty, match, last, done;
   logic              nf_have;
   logic [IDX_W-1:0]  nf_idx;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Slot classification from the registered read and the valid bit.
   assign mark_full  = valid_ff[idx_ff] && full_rd_ff;
   assign mark_empty = !valid_ff[idx_ff];
   assign match      = mark_full && (key_rd_ff == key_ff);
   assign last       = (steps_ff == IDX_W'(CAPACITY - 1));
   assign done       = match || mark_empty || last;
   assign nf_have    = have_free_ff || !mark_full;
   assign nf_idx     = have_free_ff ? free_ff : idx_ff;

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      steps_in     = steps_ff;
      free_in      = free_ff;
      have_free_in = have_free_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      hit_in       = hit_ff;
      status_in    = status_ff;
      where_in     = where_ff;
      key_out_in   = key_out_ff;
      live_in      = live_ff;
      key_we       = 1'b0;
      full_we      = 1'b0;
      full_wd      = 1'b0;
      valid_set    = 1'b0;
      valid_clear  = 1'b0;
      wa           = idx_ff;
      pop          = 1'b0;

      case (state_ff)
         // Take the next command once the response register is free.
         S_IDLE: begin
            if (head.valid && out_free) begin
               pop          = 1'b1;
               op_in        = head.cmd.op;
               key_in       = head.cmd.key;
               idx_in       = head.cmd.start;
               steps_in     = '0;
               have_free_in = 1'b0;
               hit_in       = 1'b0;
               status_in    = ST_OK;
               where_in     = '0;
               key_out_in   = '0;
               live_in      = count_ff;
               if (head.cmd.op == OP_CLEAR) begin
                  valid_clear  = 1'b1;
                  count_in     = '0;
                  live_in      = '0;
                  rsp_valid_in = 1'b1;
               end else if (head.cmd.probe && head.cmd.op != OP_INSERT &&
                            count_ff == '0) begin
                  // Lookup or delete on an empty set misses at once.
                  rsp_valid_in = 1'b1;
               end else if (head.cmd.op == OP_DELETE_AT || head.cmd.op == OP_READ ||
                            head.cmd.probe) begin
                  state_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end

         // Memories are read at idx_ff during this cycle.
         S_READ: begin
            state_in = S_EVAL;
         end

         S_EVAL: begin
            case (op_ff)
               OP_DELETE_AT: begin
                  where_in = SLOT_W'(idx_ff);
                  if (mark_full) begin
                     full_we  = 1'b1;
                     full_wd  = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                     hit_in   = 1'b1;
                  end else begin
                     status_in = ST_BAD_SLOT;
                  end
                  live_in      = count_in;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               OP_READ: begin
                  where_in = SLOT_W'(idx_ff);
                  if (mark_full) begin
                     hit_in     = 1'b1;
                     key_out_in = key_rd_ff;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               default: begin
                  if (!done) begin
                     // Move on to the next slot, wrapping at the end.
                     idx_in       = idx_ff + IDX_W'(1);
                     steps_in     = steps_ff + IDX_W'(1);
                     have_free_in = nf_have;
                     free_in      = nf_idx;
                     state_in     = S_READ;
                  end else begin
                     case (op_ff)
                        OP_LOOKUP: begin
                           hit_in   = match;
                           where_in = match ? SLOT_W'(idx_ff) : '0;
                        end
                        OP_INSERT: begin
                           if (match) begin
                              key_we   = 1'b1;
                              where_in = SLOT_W'(idx_ff);
                           end else if (nf_have) begin
                              wa        = nf_idx;
                              key_we    = 1'b1;
                              full_we   = 1'b1;
                              full_wd   = 1'b1;
                              valid_set = 1'b1;
                              count_in  = count_ff + CNT_W'(1);
                              hit_in    = 1'b1;
                              where_in  = SLOT_W'(nf_idx);
                           end else begin
                              status_in = ST_NO_FREE;
                           end
                        end
                        OP_DELETE_KEY: begin
                           if (match) begin
                              full_we  = 1'b1;
                              full_wd  = 1'b0;
                              count_in = count_ff - CNT_W'(1);
                              hit_in   = 1'b1;
                              where_in = SLOT_W'(idx_ff);
                           end
                        end
                        default: begin
                        end
                     endcase
                     live_in      = count_in;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, valid bits and registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (valid_clear) begin
            valid_ff <= '0;
         end else if (valid_set) begin
            valid_ff[wa] <= 1'b1;
         end
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      steps_ff     <= steps_in;
      free_ff      <= free_in;
      have_free_ff <= have_free_in;
      hit_ff       <= hit_in;
      status_ff    <= status_in;
      where_ff     <= where_in;
      key_out_ff   <= key_out_in;
      live_ff      <= live_in;
   end

   // Key memory.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[wa] <= key_ff;
      end
      key_rd_ff <= key_mem_ff[idx_ff];
   end

   // Full/deleted mark memory.
   always_ff @(posedge clock) begin
      if (full_we) begin
         full_mem_ff[wa] <= full_wd;
      end
      full_rd_ff <= full_mem_ff[idx_ff];
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hit        = hit_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.where      = where_ff;
   assign rsp_bus.key_out    = key_out_ff;
   assign rsp_bus.live_count = live_ff;

endmodule

### rtl/core/open_addressing_hash_set_core.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_set_core
// Linear probing hash set of 64-bit key hashes with deleted marks.
// ----------------------------------------------------------------------------
// Usage: a request beat on req_bus carries op, key and slot; every request
// gives exactly one response beat on rsp_bus, in request order, with hit,
// status, where, key_out and live_count.
// A two-entry queue takes request beats while the back end works, so the
// sender sees ready as long as the queue has room.
// A beat waits in the queue until the back end takes it. Clear, unused codes
// and probes on an empty set then answer straight from the idle state; read
// slot and delete at slot pass through the read and evaluate states; lookup,
// insert and delete by key visit up to 256 slots, each with a registered
// memory read and then a compare. The back end runs one command at a time,
// and the queue takes new requests meanwhile.
// Reset empties the table at once through per-slot valid bits; no clearing
// pass is needed. When the receiver stalls, the response holds in its
// register, the back end waits, and the queue fills and then drops ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "open_addressing_hash_set_core_defines.svh"

module open_addressing_hash_set_core (
   input  logic       clock,
   input  logic       reset,
   ohs_req_if.sink    req_bus,
   ohs_rsp_if.source  rsp_bus
);
   import ohs_pkg::*;

   queue_head_type head;
   logic           pop;

   ohs_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .head    (head),
      .pop     (pop)
   );

   ohs_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

   // The back end takes a command only from a filled queue head.
   `OHS_ASSERT_NOW(a_pop_valid, pop, head.valid, "pop from empty command queue")

   // A failed insert means every slot is full.
   `OHS_ASSERT_NOW(a_nofree_full, rsp_bus.valid && rsp_bus.status == ST_NO_FREE,
      rsp_bus.live_count == CNT_W'(CAPACITY), "no free slot reported below capacity")

   // Any error status comes with a miss.
   `OHS_ASSERT_NOW(a_err_miss, rsp_bus.valid && rsp_bus.status != ST_OK,
      !rsp_bus.hit, "hit reported with error status")

   // Taking a command while the response waits must not overwrite it.
   `OHS_ASSERT_NEXT(a_pop_out, pop && rsp_bus.valid && !rsp_bus.ready,
      0, "command taken while response register is held")

endmodule

### tb/ohs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohs_checker
// Watches the request and response channels of the hash set core, keeps its
// own copy of the table, and compares every response beat with a prediction.
// ----------------------------------------------------------------------------
module ohs_checker (
   input  logic   clock,
   input  logic   reset,
   ohs_req_if     req_bus,
   ohs_rsp_if     rsp_bus,
   output int     fail_count,
   output int     pending
);
   import ohs_pkg::*;

   localparam logic [1:0] MARK_EMPTY   = 2'd0;
   localparam logic [1:0] MARK_FULL    = 2'd1;
   localparam logic [1:0] MARK_DELETED = 2'd2;

   typedef struct packed {
      logic              hit;
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] where;
      logic [KEY_W-1:0]  key_out;
      logic [CNT_W-1:0]  live_count;
   } answer_type;

   logic [KEY_W-1:0] keys_shadow [CAPACITY];
   logic [1:0]       marks_shadow [CAPACITY];
   int               live_shadow;
   answer_type       answers_due [$];

   // Walk from the home slot; returns found index and first free slot.
   function automatic void walk_table(input logic [KEY_W-1:0] k, output bit found,
                                      output int at, output bit got_free,
                                      output int free_at);
      int home;
      int idx;
      home = int'(k % CAPACITY);
      found = 0; at = 0; got_free = 0; free_at = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         idx = (home + i) % CAPACITY;
         if (marks_shadow[idx] == MARK_DELETED) begin
            if (!got_free) begin got_free = 1; free_at = idx; end
         end else if (marks_shadow[idx] == MARK_EMPTY) begin
            if (!got_free) begin got_free = 1; free_at = idx; end
            break;
         end else if (keys_shadow[idx] == k) begin
            found = 1; at = idx;
            break;
         end
      end
   endfunction

   // Apply one request to the shadow table and return its answer.
   function automatic answer_type apply_request(logic [OP_W-1:0] op,
                                                logic [KEY_W-1:0] k,
                                                logic [SLOT_W-1:0] s);
      answer_type a;
      bit found, got_free;
      int at, free_at;
      a = '0;
      case (op)
         OP_LOOKUP: begin
            if (live_shadow != 0) begin
               walk_table(k, found, at, got_free, free_at);
               if (found) begin a.hit = 1; a.where = SLOT_W'(at); end
            end
         end
         OP_INSERT: begin
            walk_table(k, found, at, got_free, free_at);
            if (found) begin
               keys_shadow[at] = k;
               a.where = SLOT_W'(at);
            end else if (got_free) begin
               keys_shadow[free_at] = k;
               marks_shadow[free_at] = MARK_FULL;
               live_shadow++;
               a.hit = 1;
               a.where = SLOT_W'(free_at);
            end else begin
               a.status = ST_NO_FREE;
            end
         end
         OP_DELETE_KEY: begin
            if (live_shadow != 0) begin
               walk_table(k, found, at, got_free, free_at);
               if (found) begin
                  marks_shadow[at] = MARK_DELETED;
                  live_shadow--;
                  a.hit = 1;
                  a.where = SLOT_W'(at);
               end
            end
         end
         OP_DELETE_AT: begin
            a.where = s;
            if (marks_shadow[s] == MARK_FULL) begin
               marks_shadow[s] = MARK_DELETED;
               if (live_shadow != 0) live_shadow--;
               a.hit = 1;
            end else begin
               a.status = ST_BAD_SLOT;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < CAPACITY; i++) marks_shadow[i] = MARK_EMPTY;
            live_shadow = 0;
         end
         OP_READ: begin
            a.where = s;
            if (marks_shadow[s] == MARK_FULL) begin
               a.hit = 1;
               a.key_out = keys_shadow[s];
            end
         end
         default: ;
      endcase
      a.live_count = CNT_W'(live_shadow);
      return a;
   endfunction

   // Predict on each request beat, compare on each response beat.
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) marks_shadow[i] = MARK_EMPTY;
         live_shadow = 0;
         answers_due.delete();
         fail_count = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            answers_due.push_back(apply_request(req_bus.op, req_bus.key, req_bus.slot));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answers_due.size() == 0) begin
               $error("response beat with no request waiting");
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_bus.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_bus.hit);
                  fail_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  fail_count++;
               end
               if (rsp_bus.where !== want.where) begin
                  $error("where: expected %0d, got %0d", want.where, rsp_bus.where);
                  fail_count++;
               end
               if (rsp_bus.key_out !== want.key_out) begin
                  $error("key_out: expected %h, got %h", want.key_out, rsp_bus.key_out);
                  fail_count++;
               end
               if (rsp_bus.live_count !== want.live_count) begin
                  $error("live_count: expected %0d, got %0d", want.live_count,
                         rsp_bus.live_count);
                  fail_count++;
               end
            end
         end
      end
      pending = answers_due.size();
   end
endmodule

### tb/tb_open_addressing_hash_set_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_open_addressing_hash_set_core
// Drives directed and random request beats into the hash set core with random
// gaps and response stalls; the checker predicts and compares each response.
// ----------------------------------------------------------------------------
module tb_open_addressing_hash_set_core;
   import ohs_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   pending;
   int   stall_left;
   bit   stim_done = 0;
   logic [KEY_W-1:0] key_pool [16];

   ohs_req_if req_bus ();
   ohs_rsp_if rsp_bus ();

   open_addressing_hash_set_core dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus));

   ohs_checker checker_i (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .fail_count(fail_count), .pending(pending));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_bus.valid = 0;
      req_bus.op = '0;
      req_bus.key = '0;
      req_bus.slot = '0;
      rsp_bus.ready = 0;
   end

   // Response side: stall a random number of cycles before each beat.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 0;
         stall_left <= $urandom_range(0, 16);
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         rsp_bus.ready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 0;
      end else begin
         rsp_bus.ready <= 1;
      end
   end

   // Send one request beat after a gap, then wait for acceptance. Valid stays
   // high into the next beat when there is no gap.
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                            input logic [SLOT_W-1:0] s, input int gap);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.op <= op;
      req_bus.key <= k;
      req_bus.slot <= s;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic logic [KEY_W-1:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   initial begin
      int gap;
      int pick;
      logic [KEY_W-1:0] k;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty set, key extremes, collisions on one home slot.
      send_beat(OP_LOOKUP, '0, '0, 0);
      send_beat(OP_DELETE_KEY, '1, '0, 0);
      send_beat(OP_INSERT, '0, '0, 0);
      send_beat(OP_INSERT, '1, '0, 0);
      send_beat(OP_INSERT, 64'h100, '0, 0);
      send_beat(OP_INSERT, 64'h200, '0, 0);
      send_beat(OP_INSERT, 64'h100, '0, 1);
      send_beat(OP_LOOKUP, 64'h200, '0, 0);
      send_beat(OP_DELETE_KEY, 64'h100, '0, 0);
      send_beat(OP_LOOKUP, 64'h200, '0, 0);
      send_beat(OP_INSERT, 64'h300, '0, 0);
      send_beat(OP_READ, '0, 8'd0, 0);
      send_beat(OP_READ, '0, 8'd255, 0);
      send_beat(OP_READ, '0, 8'd7, 0);
      send_beat(OP_DELETE_AT, '0, 8'd255, 0);
      send_beat(OP_DELETE_AT, '0, 8'd255, 0);
      send_beat(OP_DELETE_AT, '0, 8'd9, 0);
      send_beat(3'd6, '1, '1, 0);
      send_beat(3'd7, '0, '0, 0);
      send_beat(OP_CLEAR, '0, '0, 0);
      send_beat(OP_LOOKUP, 64'h200, '0, 0);

      // Fill the whole table, then overflow it.
      for (int i = 0; i < CAPACITY; i++)
         send_beat(OP_INSERT, {$urandom, 24'd0, 8'(i)} ^ 64'(i), '0, 0);
      send_beat(OP_INSERT, wide_random(), '0, 0);
      send_beat(OP_LOOKUP, 64'hdead_beef_0000_0000, '0, 0);
      send_beat(OP_DELETE_AT, '0, 8'd128, 0);
      send_beat(OP_INSERT, 64'h5555_0000_0000_0080, '0, 0);

      // Hold off until every response is back.
      req_bus.valid <= 0;
      @(posedge clock);
      wait (pending == 0);
      send_beat(OP_CLEAR, '0, '0, 0);

      // Random: keys drawn mostly from a small pool so operations meet.
      for (int i = 0; i < 16; i++)
         key_pool[i] = (i < 8) ? ((wide_random() & 64'hffff_ffff_ffff_ff00) | 64'(i & 3))
                               : wide_random();
      for (int n = 0; n < 570; n++) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         pick = $urandom_range(0, 99);
         k = ($urandom_range(0, 4) == 0) ? wide_random() : key_pool[$urandom_range(0, 15)];
         if (pick < 35)      send_beat(OP_INSERT, k, 8'($urandom), gap);
         else if (pick < 60) send_beat(OP_LOOKUP, k, 8'($urandom), gap);
         else if (pick < 75) send_beat(OP_DELETE_KEY, k, 8'($urandom), gap);
         else if (pick < 84) send_beat(OP_READ, k, 8'($urandom_range(0, 20)), gap);
         else if (pick < 93) send_beat(OP_DELETE_AT, k, 8'($urandom_range(0, 20)), gap);
         else if (pick < 95) send_beat(OP_CLEAR, k, 8'($urandom), gap);
         else                send_beat(3'($urandom_range(0, 7)), k, 8'($urandom), gap);
      end
      req_bus.valid <= 0;
      @(posedge clock);
      stim_done = 1;
   end

   // Drain, give the block time to settle, then report.
   initial begin
      wait (stim_done);
      wait (pending == 0);
      repeat (600) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("open_addressing_hash_set_core regression: pass");
      else
         $display("open_addressing_hash_set_core regression: fail");
      $finish;
   end

   initial begin
      #50ms;
      $display("open_addressing_hash_set_core regression: fail");
      $finish;
   end
endmodule

### open_addressing_hash_set_core.f
+incdir+rtl/core
rtl/core/ohs_pkg.sv
rtl/core/ohs_if.sv
rtl/core/ohs_front.sv
rtl/core/ohs_back.sv
rtl/core/open_addressing_hash_set_core.sv
tb/ohs_checker.sv
tb/tb_open_addressing_hash_set_core.sv
